// ----- design/ghp_pkg.sv -----
package ghp_pkg;

	// default geometry of the pool and of a handle
	localparam int unsigned NUM_SLOTS_DEF  = 128;
	localparam int unsigned GEN_BITS_DEF   = 8;
	localparam int unsigned INDEX_BITS_DEF = 20;
	localparam int unsigned TYPE_BITS_DEF  = 4;

	// type stamped into every pool handle at reset
	localparam logic [7:0]  TYPE_POOL_ENTRY = 8'd1;
	localparam logic [31:0] HANDLE_NONE     = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_LOOKUP  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_BAD     = 2'd2
	} status_t;

endpackage

// ----- design/generational_handle_pool.sv -----
// Generational handle pool. Hands out 32-bit handles {type, generation, index} from a
// free stack of NUM_SLOTS entries and validates them on release and lookup. opcode
// selects allocate, release or lookup; handle_in is ignored on allocate. A result beat
// carries status (ok, no free slot, or invalid / stale handle / nothing to release), the
// new or echoed handle, the low 7 bits of its slot index and the number of live handles
// after the operation. Throughput is one beat per clock unless out_stall holds an
// untaken result: the input beat is registered together with the synchronous reads of
// the free stack and slot table in the request stage, and the result is computed and
// committed from there into the output register, which drives out_valid, once that
// register is free to take it. Back-to-back dependencies are
// handled by computing the next read address from the operation being committed and by
// forwarding same-address writes around both memories. in_stall rises only while the
// output register holds an untaken beat and the stage behind it is occupied. Both stores
// are ready right after reset with no clearing pass: per-slot valid bits stand in for the
// invalid-handle marker of the slot table, and per-entry written bits make untouched
// free-stack entries read as their reset handle (type 1, generation 0, index = entry).
module generational_handle_pool #(
	parameter int unsigned NUM_SLOTS  = ghp_pkg::NUM_SLOTS_DEF,
	parameter int unsigned GEN_BITS   = ghp_pkg::GEN_BITS_DEF,
	parameter int unsigned INDEX_BITS = ghp_pkg::INDEX_BITS_DEF,
	parameter int unsigned TYPE_BITS  = ghp_pkg::TYPE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [31:0] handle_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] handle_out,
	output logic [6:0]  slot_index,
	output logic [7:0]  live_count
);
	import ghp_pkg::*;

	// address width of both stores, and stack pointer width (holds 0..NUM_SLOTS)
	localparam int unsigned SLOT_AW = $clog2(NUM_SLOTS);
	localparam int unsigned SP_W    = $clog2(NUM_SLOTS + 1);

	// handle field masks; fields above bit 31 fall off the handle
	localparam logic [63:0] IDX_MASK64 = (64'd1 << INDEX_BITS) - 64'd1;
	localparam logic [63:0] GEN_MASK64 = ((64'd1 << GEN_BITS) - 64'd1) << INDEX_BITS;
	localparam logic [63:0] TYPE_ONE64 =
		((64'(TYPE_POOL_ENTRY)) & ((64'd1 << TYPE_BITS) - 64'd1)) << (INDEX_BITS + GEN_BITS);
	localparam logic [63:0] GEN_INC64  = 64'd1 << INDEX_BITS;
	localparam logic [31:0] IDX_MASK   = IDX_MASK64[31:0];
	localparam logic [31:0] GEN_MASK   = GEN_MASK64[31:0];
	localparam logic [31:0] TYPE_ONE   = TYPE_ONE64[31:0];
	localparam logic [31:0] GEN_INC    = GEN_INC64[31:0];
	localparam logic [31:0] SLOTS_32   = 32'(NUM_SLOTS);

	// storage
	logic [31:0]          fs_mem [NUM_SLOTS];
	logic [31:0]          sh_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] fs_written_q;
	logic [NUM_SLOTS-1:0] slot_valid_q;
	logic [SP_W-1:0]      sp_q;

	// request stage
	logic                 s1_valid_q;
	opcode_t              op_s1;
	logic [31:0]          h_s1;
	logic [31:0]          fs_rd_s1;
	logic                 fs_byp_s1;
	logic [31:0]          fs_bypd_s1;
	logic [31:0]          sh_rd_s1;
	logic                 sh_byp_s1;
	logic [31:0]          sh_bypd_s1;

	// result register
	logic                 out_valid_q;
	status_t              status_q;
	logic [31:0]          handle_out_q;
	logic [6:0]           slot_index_q;
	logic [7:0]           live_count_q;

	// handshake
	logic                 s1_adv;
	logic                 commit;
	logic                 accept;

	// stage 1 evaluation
	logic [31:0]          hidx;
	logic                 h_in_range;
	logic [SLOT_AW-1:0]   h_slot;
	logic [31:0]          slot_data;
	logic                 live;
	logic [SLOT_AW-1:0]   sp_slot;
	logic [31:0]          top;
	logic [31:0]          nh;
	logic [31:0]          nidx;
	logic                 n_in_range;
	logic [SLOT_AW-1:0]   n_slot;
	status_t              status_d;
	logic [31:0]          hout_d;
	logic [6:0]           sidx_d;
	logic [SP_W-1:0]      sp_d;
	logic                 alloc_ok;
	logic                 rel_ok;

	// memory ports
	logic                 fs_we;
	logic [SLOT_AW-1:0]   fs_waddr;
	logic [SLOT_AW-1:0]   fs_raddr;
	logic                 sh_we;
	logic [SLOT_AW-1:0]   sh_raddr;
	logic [SP_W-1:0]      sp_new;
	logic [SP_W-1:0]      sp_dec;
	logic [31:0]          hin_idx;

	assign s1_adv   = !out_valid_q || !out_stall;
	assign commit   = s1_valid_q && s1_adv;
	assign in_stall = s1_valid_q && !s1_adv;
	assign accept   = in_valid && !in_stall;

	// live test of the registered handle
	always_comb begin
		hidx       = h_s1 & IDX_MASK;
		h_in_range = hidx < SLOTS_32;
		h_slot     = hidx[SLOT_AW-1:0];
		slot_data  = sh_byp_s1 ? sh_bypd_s1 : sh_rd_s1;
		live       = h_in_range && slot_valid_q[h_slot] && (slot_data == h_s1);
	end

	// top of the free stack, bumped to the next generation
	always_comb begin
		sp_slot = sp_q[SLOT_AW-1:0];
		if (fs_byp_s1) begin
			top = fs_bypd_s1;
		end else if (fs_written_q[sp_slot]) begin
			top = fs_rd_s1;
		end else begin
			top = TYPE_ONE | (32'(sp_slot) & IDX_MASK);
		end
		nh         = (top & ~GEN_MASK) | ((( top & GEN_MASK) + GEN_INC) & GEN_MASK);
		nidx       = nh & IDX_MASK;
		n_in_range = nidx < SLOTS_32;
		n_slot     = nidx[SLOT_AW-1:0];
	end

	assign sp_dec = sp_q - SP_W'(1);

	always_comb begin
		status_d = ST_BAD;
		hout_d   = h_s1;
		sidx_d   = 7'(hidx);
		sp_d     = sp_q;
		alloc_ok = 1'b0;
		rel_ok   = 1'b0;
		case (op_s1)
			OP_ALLOC: begin
				if (sp_q >= SP_W'(NUM_SLOTS)) begin
					status_d = ST_NO_FREE;
					hout_d   = HANDLE_NONE;
					sidx_d   = 7'd0;
				end else begin
					hout_d = nh;
					sidx_d = 7'(nidx);
					if (n_in_range) begin
						alloc_ok = 1'b1;
						status_d = ST_OK;
						sp_d     = sp_q + SP_W'(1);
					end
				end
			end
			OP_RELEASE: begin
				if (sp_q != '0 && live) begin
					rel_ok   = 1'b1;
					status_d = ST_OK;
					sp_d     = sp_dec;
				end
			end
			OP_LOOKUP: begin
				status_d = live ? ST_OK : ST_BAD;
			end
			default: begin
				status_d = ST_BAD;
			end
		endcase
	end

	// writes happen as the request leaves stage 1
	assign fs_we    = commit && rel_ok;
	assign fs_waddr = sp_dec[SLOT_AW-1:0];
	assign sh_we    = commit && alloc_ok;

	// next request reads against the pointer this commit leaves behind
	assign sp_new   = commit ? sp_d : sp_q;
	assign fs_raddr = sp_new[SLOT_AW-1:0];
	assign hin_idx  = handle_in & IDX_MASK;
	assign sh_raddr = hin_idx[SLOT_AW-1:0];

	always_ff @(posedge clk) begin
		if (fs_we) begin
			fs_mem[fs_waddr] <= h_s1;
		end
		if (sh_we) begin
			sh_mem[n_slot] <= nh;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= opcode_t'(opcode);
			h_s1       <= handle_in;
			fs_rd_s1   <= fs_mem[fs_raddr];
			sh_rd_s1   <= sh_mem[sh_raddr];
			fs_byp_s1  <= fs_we && (fs_waddr == fs_raddr);
			fs_bypd_s1 <= h_s1;
			sh_byp_s1  <= sh_we && (n_slot == sh_raddr);
			sh_bypd_s1 <= nh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			sp_q         <= '0;
			fs_written_q <= '0;
			slot_valid_q <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (commit) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= s1_valid_q;
			end
			if (commit) begin
				sp_q <= sp_d;
			end
			if (fs_we) begin
				fs_written_q[fs_waddr] <= 1'b1;
				slot_valid_q[h_slot]   <= 1'b0;
			end
			if (sh_we) begin
				slot_valid_q[n_slot] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q     <= status_d;
			handle_out_q <= hout_d;
			slot_index_q <= sidx_d;
			live_count_q <= 8'(sp_d);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign handle_out = handle_out_q;
	assign slot_index = slot_index_q;
	assign live_count = live_count_q;

`ifndef SYNTHESIS
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(NUM_SLOTS))
		else $error("stack pointer beyond pool size");

	a_live_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_valid_q) == int'(sp_q))
		else $error("live count disagrees with slot valid bits");

	a_alloc_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && alloc_ok) |=> slot_valid_q[$past(n_slot)])
		else $error("allocated slot not marked valid");

	a_release_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && rel_ok) |=> (sp_q == $past(sp_dec)) && !slot_valid_q[$past(h_slot)])
		else $error("release did not free its slot");
`endif

endmodule
